FILE: sv/ppm_pkg.sv
// types, constants and register codes shared by the egress rate and fanout monitor
// no dependencies; used by ppm_front, ppm_back and the top level
package ppm_pkg;

    localparam int MAX_PROCS  = 64;
    localparam int HIST_DEPTH = 256;   // power of two, history is a ring per slot

    localparam int NSLOTS  = MAX_PROCS + 1;
    localparam int SLOT_W  = $clog2(NSLOTS);
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int LEN_W   = $clog2(HIST_DEPTH + 1);
    localparam int TRK_W   = $clog2(NSLOTS + 1);
    localparam int HADDR_W = SLOT_W + HIST_AW;
    localparam int HMEM_DEPTH = NSLOTS * HIST_DEPTH;

    localparam int PID_W  = 22;
    localparam int REM_W  = 32;
    localparam int TIME_W = 48;
    localparam int CFG_W  = 16;
    localparam int WMS_W  = 26;       // up to 65535 seconds in ms

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);

    localparam logic [CFG_W-1:0] DEFAULT_WINDOW = 16'd10;
    localparam logic [CFG_W-1:0] DEFAULT_RATE   = 16'd10;
    localparam logic [CFG_W-1:0] DEFAULT_FANOUT = 16'd8;
    localparam logic [9:0]       MS_PER_SEC     = 10'd1000;
    localparam logic [7:0]       RATE_BASE      = 8'd25;
    localparam logic [7:0]       FANOUT_BASE    = 8'd30;
    localparam logic [7:0]       OVER_CAP       = 8'd40;
    localparam logic [7:0]       SCORE_CAP      = 8'd100;

    // action codes of the request
    localparam logic [1:0] ACT_CONNECT = 2'd0;
    localparam logic [1:0] ACT_FORGET  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_WINDOW = 2'd0;
    localparam logic [1:0] CFG_RATE   = 2'd1;
    localparam logic [1:0] CFG_FANOUT = 2'd2;

    typedef enum logic [1:0] {
        K_IGNORE,
        K_CONNECT,
        K_FORGET
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [PID_W-1:0]   pid;
        logic [REM_W-1:0]   remote;
        logic [TIME_W-1:0]  now;
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] window_secs;
        logic [CFG_W-1:0] rate_thr;
        logic [CFG_W-1:0] fanout_thr;
    } t_cfg;

    typedef struct packed {
        logic [6:0] score;
        logic       rate_hit;
        logic       fanout_hit;
        logic [8:0] window_count;
        logic [8:0] distinct_count;
        logic [6:0] tracked_count;
    } t_result;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [TIME_W-1:0]  last_ms;
        logic [HIST_AW-1:0] head;
        logic [LEN_W-1:0]   len;
    } t_meta;

    typedef struct packed {
        logic [TIME_W-1:0] t;
        logic [REM_W-1:0]  remote;
    } t_hist;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_A,
        S_FIND_B,
        S_ALLOC,
        S_DROP_A,
        S_DROP_B,
        S_APPEND,
        S_CNT_A,
        S_CNT_B,
        S_DIST_A,
        S_DIST_B,
        S_META,
        S_EVICT_A,
        S_EVICT_B,
        S_CAP,
        S_SCORE,
        S_DONE
    } t_state;

endpackage

FILE: sv/ppm_front.sv
// front end: classifies incoming requests and holds them in a short queue
// depends on ppm_pkg
module ppm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_action,
    input  logic [ppm_pkg::PID_W-1:0]   i_actor_pid,
    input  logic [ppm_pkg::REM_W-1:0]   i_remote_id,
    input  logic [ppm_pkg::TIME_W-1:0]  i_time_ms,
    output logic                        o_cmd_valid,
    output ppm_pkg::t_cmd               o_cmd,
    input  logic                        i_cmd_pop
);

    ppm_pkg::t_cmd                  r_q [ppm_pkg::CMDQ_DEPTH];
    logic [ppm_pkg::CMDQ_AW-1:0]    r_wp, r_rp;
    logic [ppm_pkg::CMDQ_AW:0]      r_cnt;
    ppm_pkg::t_cmd                  cls;
    logic                           do_push, do_pop;

    // classify the request
    always_comb begin
        cls.pid    = i_actor_pid;
        cls.remote = i_remote_id;
        cls.now    = i_time_ms;
        if (i_action == ppm_pkg::ACT_FORGET) begin
            cls.kind = ppm_pkg::K_FORGET;
        end else if (i_action == ppm_pkg::ACT_CONNECT && i_actor_pid != '0) begin
            cls.kind = ppm_pkg::K_CONNECT;
        end else begin
            cls.kind = ppm_pkg::K_IGNORE;
        end
    end

    assign full        = (r_cnt == (ppm_pkg::CMDQ_AW+1)'(ppm_pkg::CMDQ_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];
    assign do_push     = push && !full;
    assign do_pop      = i_cmd_pop && o_cmd_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

FILE: sv/ppm_back.sv
// back end: slot table, per-pid history rings, window counting, scoring, eviction
// depends on ppm_pkg; fed by ppm_front, result register read by the top level
module ppm_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppm_pkg::t_cfg       i_cfg,
    input  logic                i_cmd_valid,
    input  ppm_pkg::t_cmd       i_cmd,
    output logic                o_cmd_pop,
    output logic                o_res_valid,
    output ppm_pkg::t_result    o_res,
    input  logic                i_res_pop
);

    ppm_pkg::t_state                r_state, n_state;
    ppm_pkg::t_cmd                  r_cmd, n_cmd;
    logic [ppm_pkg::NSLOTS-1:0]     r_valid, n_valid;
    logic [ppm_pkg::TRK_W-1:0]      r_tracked, n_tracked;
    logic [ppm_pkg::WMS_W-1:0]      r_wms, n_wms;
    logic [ppm_pkg::SLOT_W-1:0]     r_s, n_s;
    logic [ppm_pkg::SLOT_W-1:0]     r_slot, n_slot;
    logic [ppm_pkg::SLOT_W-1:0]     r_free, n_free;
    logic                           r_have_free, n_have_free;
    logic [ppm_pkg::HIST_AW-1:0]    r_head, n_head;
    logic [ppm_pkg::LEN_W-1:0]      r_len, n_len;
    logic [ppm_pkg::LEN_W-1:0]      r_drop, n_drop;
    logic [ppm_pkg::LEN_W-1:0]      r_i, n_i;
    logic [ppm_pkg::LEN_W-1:0]      r_j, n_j;
    logic [ppm_pkg::REM_W-1:0]      r_rem, n_rem;
    logic [ppm_pkg::LEN_W-1:0]      r_cnt, n_cnt;
    logic [ppm_pkg::LEN_W-1:0]      r_dist, n_dist;
    logic [ppm_pkg::TIME_W-1:0]     r_min_last, n_min_last;
    logic [ppm_pkg::SLOT_W-1:0]     r_min_slot, n_min_slot;
    logic                           r_have_min, n_have_min;
    logic [6:0]                     r_score, n_score;
    logic                           r_rhit, n_rhit;
    logic                           r_fhit, n_fhit;
    logic                           r_res_valid, n_res_valid;
    ppm_pkg::t_result               r_res, n_res;

    ppm_pkg::t_meta                 r_meta_mem [ppm_pkg::NSLOTS];
    ppm_pkg::t_meta                 q_meta;
    logic                           meta_we;
    logic [ppm_pkg::SLOT_W-1:0]     meta_addr;
    ppm_pkg::t_meta                 meta_wdata;

    ppm_pkg::t_hist                 r_hist_mem [ppm_pkg::HMEM_DEPTH];
    ppm_pkg::t_hist                 q_hist;
    logic                           hist_we;
    logic [ppm_pkg::HIST_AW-1:0]    hist_idx;
    logic [ppm_pkg::HADDR_W-1:0]    hist_addr;
    ppm_pkg::t_hist                 hist_wdata;

    logic                           last_slot;
    logic                           hist_in_win;
    logic                           meta_idle;
    logic [ppm_pkg::LEN_W-1:0]      d_eff, new_len;
    logic [ppm_pkg::HIST_AW-1:0]    new_head;
    logic [ppm_pkg::CFG_W-1:0]      win_eff;
    logic [ppm_pkg::CFG_W-1:0]      cnt16, dist16, over;
    logic [ppm_pkg::CFG_W:0]        over2;
    logic [7:0]                     part_r, part_f, sum;

    assign last_slot = (r_s == ppm_pkg::SLOT_W'(ppm_pkg::NSLOTS - 1));

    // window and idle tests on the registered memory outputs
    assign hist_in_win = ({1'b0, q_hist.t} + (ppm_pkg::TIME_W+1)'(r_wms))
                         >= {1'b0, r_cmd.now};
    assign meta_idle   = ({1'b0, q_meta.last_ms} + (ppm_pkg::TIME_W+1)'({r_wms, 2'b00}))
                         < {1'b0, r_cmd.now};

    // history cap: at most one extra drop when the ring is full
    always_comb begin
        if ((r_len - r_drop) >= ppm_pkg::LEN_W'(ppm_pkg::HIST_DEPTH)) begin
            d_eff = r_len + 1'b1 - ppm_pkg::LEN_W'(ppm_pkg::HIST_DEPTH);
        end else begin
            d_eff = r_drop;
        end
        new_head = r_head + d_eff[ppm_pkg::HIST_AW-1:0];
        new_len  = r_len - d_eff;
    end

    // score terms
    always_comb begin
        win_eff = (i_cfg.window_secs != '0) ? i_cfg.window_secs : ppm_pkg::DEFAULT_WINDOW;
        cnt16   = ppm_pkg::CFG_W'(r_cnt);
        dist16  = ppm_pkg::CFG_W'(r_dist);
        over    = cnt16 - i_cfg.rate_thr;
        over2   = {dist16 - i_cfg.fanout_thr, 1'b0};
        if (cnt16 >= i_cfg.rate_thr) begin
            part_r = ppm_pkg::RATE_BASE + ((over < 16'(ppm_pkg::OVER_CAP)) ?
                     over[7:0] : ppm_pkg::OVER_CAP);
        end else begin
            part_r = '0;
        end
        if (dist16 >= i_cfg.fanout_thr) begin
            part_f = ppm_pkg::FANOUT_BASE + ((over2 < 17'(ppm_pkg::OVER_CAP)) ?
                     over2[7:0] : ppm_pkg::OVER_CAP);
        end else begin
            part_f = '0;
        end
        sum = part_r + part_f;
    end

    // history address select
    always_comb begin
        case (r_state)
            ppm_pkg::S_DROP_A: hist_idx = r_head + r_drop[ppm_pkg::HIST_AW-1:0];
            ppm_pkg::S_DIST_A: hist_idx = r_head + r_j[ppm_pkg::HIST_AW-1:0];
            ppm_pkg::S_APPEND: hist_idx = new_head + new_len[ppm_pkg::HIST_AW-1:0];
            default:           hist_idx = r_head + r_i[ppm_pkg::HIST_AW-1:0];
        endcase
        hist_addr = {r_slot, hist_idx};
    end

    // sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_valid     = r_valid;
        n_tracked   = r_tracked;
        n_wms       = r_wms;
        n_s         = r_s;
        n_slot      = r_slot;
        n_free      = r_free;
        n_have_free = r_have_free;
        n_head      = r_head;
        n_len       = r_len;
        n_drop      = r_drop;
        n_i         = r_i;
        n_j         = r_j;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_dist      = r_dist;
        n_min_last  = r_min_last;
        n_min_slot  = r_min_slot;
        n_have_min  = r_have_min;
        n_score     = r_score;
        n_rhit      = r_rhit;
        n_fhit      = r_fhit;
        n_res_valid = r_res_valid;
        n_res       = r_res;
        o_cmd_pop   = 1'b0;
        meta_we     = 1'b0;
        meta_addr   = r_s;
        meta_wdata  = '0;
        hist_we     = 1'b0;
        hist_wdata  = '0;

        if (r_res_valid && i_res_pop) begin
            n_res_valid = 1'b0;
        end

        case (r_state)
            ppm_pkg::S_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop   = 1'b1;
                    n_cmd       = i_cmd;
                    n_wms       = ppm_pkg::WMS_W'(win_eff) *
                                  ppm_pkg::WMS_W'(ppm_pkg::MS_PER_SEC);
                    n_s         = '0;
                    n_have_free = 1'b0;
                    n_cnt       = '0;
                    n_dist      = '0;
                    n_score     = '0;
                    n_rhit      = 1'b0;
                    n_fhit      = 1'b0;
                    if (i_cmd.kind == ppm_pkg::K_IGNORE) begin
                        n_state = ppm_pkg::S_DONE;
                    end else begin
                        n_state = ppm_pkg::S_FIND_A;
                    end
                end
            end
            // look up the pid, noting the lowest free slot on the way
            ppm_pkg::S_FIND_A: begin
                if (r_valid[r_s]) begin
                    n_state = ppm_pkg::S_FIND_B;
                end else begin
                    if (!r_have_free) begin
                        n_free      = r_s;
                        n_have_free = 1'b1;
                    end
                    if (last_slot) begin
                        n_state = (r_cmd.kind == ppm_pkg::K_CONNECT) ?
                                  ppm_pkg::S_ALLOC : ppm_pkg::S_DONE;
                    end else begin
                        n_s = r_s + 1'b1;
                    end
                end
            end
            ppm_pkg::S_FIND_B: begin
                if (q_meta.pid == r_cmd.pid) begin
                    if (r_cmd.kind == ppm_pkg::K_FORGET) begin
                        n_valid[r_s] = 1'b0;
                        n_tracked    = r_tracked - 1'b1;
                        n_state      = ppm_pkg::S_DONE;
                    end else begin
                        n_slot  = r_s;
                        n_head  = q_meta.head;
                        n_len   = q_meta.len;
                        n_drop  = '0;
                        n_state = ppm_pkg::S_DROP_A;
                    end
                end else if (last_slot) begin
                    n_state = (r_cmd.kind == ppm_pkg::K_CONNECT) ?
                              ppm_pkg::S_ALLOC : ppm_pkg::S_DONE;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = ppm_pkg::S_FIND_A;
                end
            end
            ppm_pkg::S_ALLOC: begin
                n_slot          = r_free;
                n_valid[r_free] = 1'b1;
                n_tracked       = r_tracked + 1'b1;
                n_head          = '0;
                n_len           = '0;
                n_drop          = '0;
                n_state         = ppm_pkg::S_DROP_A;
            end
            // drop leading entries that fell out of the window
            ppm_pkg::S_DROP_A: begin
                n_state = (r_drop < r_len) ? ppm_pkg::S_DROP_B : ppm_pkg::S_APPEND;
            end
            ppm_pkg::S_DROP_B: begin
                if (!hist_in_win) begin
                    n_drop  = r_drop + 1'b1;
                    n_state = ppm_pkg::S_DROP_A;
                end else begin
                    n_state = ppm_pkg::S_APPEND;
                end
            end
            ppm_pkg::S_APPEND: begin
                hist_we           = 1'b1;
                hist_wdata.t      = r_cmd.now;
                hist_wdata.remote = r_cmd.remote;
                n_head            = new_head;
                n_len             = new_len + 1'b1;
                n_i               = '0;
                n_state           = ppm_pkg::S_CNT_A;
            end
            // count in-window entries; each one is checked against earlier ones
            ppm_pkg::S_CNT_A: begin
                n_state = (r_i == r_len) ? ppm_pkg::S_META : ppm_pkg::S_CNT_B;
            end
            ppm_pkg::S_CNT_B: begin
                if (hist_in_win) begin
                    n_cnt   = r_cnt + 1'b1;
                    n_rem   = q_hist.remote;
                    n_j     = '0;
                    n_state = ppm_pkg::S_DIST_A;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ppm_pkg::S_CNT_A;
                end
            end
            ppm_pkg::S_DIST_A: begin
                if (r_j == r_i) begin
                    n_dist  = r_dist + 1'b1;
                    n_i     = r_i + 1'b1;
                    n_state = ppm_pkg::S_CNT_A;
                end else begin
                    n_state = ppm_pkg::S_DIST_B;
                end
            end
            ppm_pkg::S_DIST_B: begin
                if (hist_in_win && q_hist.remote == r_rem) begin
                    n_i     = r_i + 1'b1;
                    n_state = ppm_pkg::S_CNT_A;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = ppm_pkg::S_DIST_A;
                end
            end
            ppm_pkg::S_META: begin
                meta_we            = 1'b1;
                meta_addr          = r_slot;
                meta_wdata.pid     = r_cmd.pid;
                meta_wdata.last_ms = r_cmd.now;
                meta_wdata.head    = r_head;
                meta_wdata.len     = r_len;
                n_s                = '0;
                n_have_min         = 1'b0;
                n_state            = ppm_pkg::S_EVICT_A;
            end
            // drop idle pids and find the oldest survivor
            ppm_pkg::S_EVICT_A: begin
                if (r_valid[r_s]) begin
                    n_state = ppm_pkg::S_EVICT_B;
                end else if (last_slot) begin
                    n_state = ppm_pkg::S_CAP;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            ppm_pkg::S_EVICT_B: begin
                if (meta_idle) begin
                    n_valid[r_s] = 1'b0;
                    n_tracked    = r_tracked - 1'b1;
                end else if (!r_have_min || q_meta.last_ms < r_min_last) begin
                    n_min_last = q_meta.last_ms;
                    n_min_slot = r_s;
                    n_have_min = 1'b1;
                end
                if (last_slot) begin
                    n_state = ppm_pkg::S_CAP;
                end else begin
                    n_s     = r_s + 1'b1;
                    n_state = ppm_pkg::S_EVICT_A;
                end
            end
            ppm_pkg::S_CAP: begin
                if (r_tracked > ppm_pkg::TRK_W'(ppm_pkg::MAX_PROCS) && r_have_min) begin
                    n_valid[r_min_slot] = 1'b0;
                    n_tracked           = r_tracked - 1'b1;
                end
                n_state = ppm_pkg::S_SCORE;
            end
            ppm_pkg::S_SCORE: begin
                n_score = (sum > ppm_pkg::SCORE_CAP) ? ppm_pkg::SCORE_CAP[6:0] : sum[6:0];
                n_rhit  = (cnt16 >= i_cfg.rate_thr);
                n_fhit  = (dist16 >= i_cfg.fanout_thr);
                n_state = ppm_pkg::S_DONE;
            end
            ppm_pkg::S_DONE: begin
                if (!r_res_valid) begin
                    n_res_valid            = 1'b1;
                    n_res.score            = r_score;
                    n_res.rate_hit         = r_rhit;
                    n_res.fanout_hit       = r_fhit;
                    n_res.window_count     = 9'(r_cnt);
                    n_res.distinct_count   = 9'(r_dist);
                    n_res.tracked_count    = 7'(r_tracked);
                    n_state                = ppm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ppm_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ppm_pkg::S_IDLE;
            r_valid     <= '0;
            r_tracked   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_tracked   <= n_tracked;
            r_res_valid <= n_res_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_wms       <= n_wms;
        r_s         <= n_s;
        r_slot      <= n_slot;
        r_free      <= n_free;
        r_have_free <= n_have_free;
        r_head      <= n_head;
        r_len       <= n_len;
        r_drop      <= n_drop;
        r_i         <= n_i;
        r_j         <= n_j;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_dist      <= n_dist;
        r_min_last  <= n_min_last;
        r_min_slot  <= n_min_slot;
        r_have_min  <= n_have_min;
        r_score     <= n_score;
        r_rhit      <= n_rhit;
        r_fhit      <= n_fhit;
        r_res       <= n_res;
    end

    // slot metadata memory
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[meta_addr] <= meta_wdata;
        end
        q_meta <= r_meta_mem[meta_addr];
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            r_hist_mem[hist_addr] <= hist_wdata;
        end
        q_hist <= r_hist_mem[hist_addr];
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

FILE: sv/per_process_egress_rate_fanout_monitor.sv
// top level of the per-process egress rate and fanout monitor
// depends on ppm_pkg, ppm_front and ppm_back
//
// Each request is a connection event (pid, hashed remote id, ms time), a forget or an ignored
// item, and gives exactly one result. Requests enter a two-deep queue and are worked one at a
// time by a sequencer over a single-port slot table (65 entries) and a single-port history
// memory holding a ring of 256 entries per slot. An ignored request goes straight to its result;
// a forget walks the slot table. A connection event walks the slot table for the pid lookup,
// drops stale entries, then for each stored entry compares it against earlier entries for the
// distinct-remote count, then walks the slot table again for idle and capacity eviction. The
// distinct-remote compare walks the history memory port over pairs of stored entries. No
// clearing pass is needed after reset. Configuration writes are always ready and must be made
// while the block is idle.
module per_process_egress_rate_fanout_monitor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  i_action,
    input  logic [21:0]                 i_actor_pid,
    input  logic [31:0]                 i_remote_id,
    input  logic [47:0]                 i_time_ms,
    output logic                        empty,
    input  logic                        pop,
    output logic [6:0]                  o_score,
    output logic                        o_rate_hit,
    output logic                        o_fanout_hit,
    output logic [8:0]                  o_window_count,
    output logic [8:0]                  o_distinct_count,
    output logic [6:0]                  o_tracked_count,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [1:0]                  i_cfg_index,
    input  logic [15:0]                 i_cfg_data
);

    ppm_pkg::t_cfg      r_cfg;
    ppm_pkg::t_cmd      cmd;
    logic               cmd_valid, cmd_pop;
    logic               res_valid;
    ppm_pkg::t_result   res;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_secs <= ppm_pkg::DEFAULT_WINDOW;
            r_cfg.rate_thr    <= ppm_pkg::DEFAULT_RATE;
            r_cfg.fanout_thr  <= ppm_pkg::DEFAULT_FANOUT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ppm_pkg::CFG_WINDOW: r_cfg.window_secs <= i_cfg_data;
                ppm_pkg::CFG_RATE:   r_cfg.rate_thr    <= i_cfg_data;
                ppm_pkg::CFG_FANOUT: r_cfg.fanout_thr  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    ppm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_action    (i_action),
        .i_actor_pid (i_actor_pid),
        .i_remote_id (i_remote_id),
        .i_time_ms   (i_time_ms),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    ppm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_pop   (pop)
    );

    // result ports
    assign empty            = !res_valid;
    assign o_score          = res.score;
    assign o_rate_hit       = res.rate_hit;
    assign o_fanout_hit     = res.fanout_hit;
    assign o_window_count   = res.window_count;
    assign o_distinct_count = res.distinct_count;
    assign o_tracked_count  = res.tracked_count;

endmodule

FILE: tb/sv/egress_monitor_checker.sv
// checker for the per-process egress rate and fanout monitor: watches the request,
// result and register channels, predicts each result and compares; depends on ppm_pkg
module egress_monitor_checker
    import ppm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  logic                full,
    input  logic [1:0]          i_action,
    input  logic [PID_W-1:0]    i_actor_pid,
    input  logic [REM_W-1:0]    i_remote_id,
    input  logic [TIME_W-1:0]   i_time_ms,
    input  logic                empty,
    input  logic                pop,
    input  logic [6:0]          o_score,
    input  logic                o_rate_hit,
    input  logic                o_fanout_hit,
    input  logic [8:0]          o_window_count,
    input  logic [8:0]          o_distinct_count,
    input  logic [6:0]          o_tracked_count,
    input  logic                i_cfg_valid,
    input  logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_data,
    output int                  mismatches,
    output int                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow registers and per-pid history
    logic [CFG_W-1:0]  win_secs, rate_thr, fanout_thr;
    logic              live [NSLOTS];
    logic [PID_W-1:0]  owner [NSLOTS];
    logic [63:0]       last_seen [NSLOTS];
    int                hlen [NSLOTS];
    logic [63:0]       h_time [NSLOTS][HIST_DEPTH];
    logic [REM_W-1:0]  h_rem [NSLOTS][HIST_DEPTH];
    t_result           expected_results[$];

    assign outstanding = expected_results.size();

    function automatic int live_count();
        int n;
        n = 0;
        for (int s = 0; s < NSLOTS; s++) if (live[s]) n++;
        return n;
    endfunction

    function automatic int slot_of(logic [PID_W-1:0] pid);
        for (int s = 0; s < NSLOTS; s++) if (live[s] && owner[s] == pid) return s;
        return -1;
    endfunction

    // idle pids first, then oldest beyond capacity, lowest slot on ties
    function automatic void evict(logic [63:0] now, logic [63:0] wms);
        int oldest;
        for (int s = 0; s < NSLOTS; s++)
            if (live[s] && last_seen[s] + 4 * wms < now) live[s] = 1'b0;
        while (live_count() > MAX_PROCS) begin
            oldest = -1;
            for (int s = 0; s < NSLOTS; s++)
                if (live[s] && (oldest < 0 || last_seen[s] < last_seen[oldest])) oldest = s;
            live[oldest] = 1'b0;
        end
    endfunction

    // update the pid tables for one request and work out its result
    function automatic t_result score_request(logic [1:0] act, logic [PID_W-1:0] pid,
                                              logic [REM_W-1:0] rem, logic [TIME_W-1:0] t);
        t_result     r;
        logic [63:0] now, wms;
        int          s, len, drop, cnt, dcount, scr, over;
        bit          seen, rhit, fhit;
        now = {16'd0, t};
        cnt = 0; dcount = 0; scr = 0; rhit = 0; fhit = 0;
        if (act == ACT_FORGET) begin
            s = slot_of(pid);
            if (s >= 0) live[s] = 1'b0;
        end else if (act == ACT_CONNECT && pid != 0) begin
            wms = (win_secs == 0 ? 64'd10 : 64'(win_secs)) * 64'd1000;
            s = slot_of(pid);
            if (s < 0) begin
                for (int k = NSLOTS - 1; k >= 0; k--) if (!live[k]) s = k;
                live[s] = 1'b1;
                owner[s] = pid;
                hlen[s] = 0;
            end
            len = hlen[s];
            // drop leading stale entries, then keep the newest ones under the cap
            drop = 0;
            while (drop < len && h_time[s][drop] + wms < now) drop++;
            if (len + 1 - drop > HIST_DEPTH) drop = len + 1 - HIST_DEPTH;
            for (int i = 0; i < len - drop; i++) begin
                h_time[s][i] = h_time[s][i + drop];
                h_rem[s][i]  = h_rem[s][i + drop];
            end
            len = len - drop;
            h_time[s][len] = now;
            h_rem[s][len]  = rem;
            len++;
            hlen[s] = len;
            last_seen[s] = now;
            // count in-window entries and distinct remotes among them
            for (int i = 0; i < len; i++) begin
                if (h_time[s][i] + wms >= now) begin
                    cnt++;
                    seen = 0;
                    for (int j = 0; j < i; j++)
                        if (h_time[s][j] + wms >= now && h_rem[s][j] == h_rem[s][i]) seen = 1;
                    if (!seen) dcount++;
                end
            end
            if (cnt >= int'(rate_thr)) begin
                over = cnt - int'(rate_thr);
                scr += int'(RATE_BASE) + (over < int'(OVER_CAP) ? over : int'(OVER_CAP));
                rhit = 1;
            end
            if (dcount >= int'(fanout_thr)) begin
                over = (dcount - int'(fanout_thr)) * 2;
                scr += int'(FANOUT_BASE) + (over < int'(OVER_CAP) ? over : int'(OVER_CAP));
                fhit = 1;
            end
            if (scr > int'(SCORE_CAP)) scr = int'(SCORE_CAP);
            evict(now, wms);
        end
        r.score          = 7'(scr);
        r.rate_hit       = rhit;
        r.fanout_hit     = fhit;
        r.window_count   = 9'(cnt);
        r.distinct_count = 9'(dcount);
        r.tracked_count  = 7'(live_count());
        return r;
    endfunction

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            win_secs   = DEFAULT_WINDOW;
            rate_thr   = DEFAULT_RATE;
            fanout_thr = DEFAULT_FANOUT;
            for (int s = 0; s < NSLOTS; s++) begin
                live[s] = 1'b0;
                hlen[s] = 0;
            end
            expected_results.delete();
            mismatches = 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW: win_secs   = i_cfg_data;
                    CFG_RATE:   rate_thr   = i_cfg_data;
                    CFG_FANOUT: fanout_thr = i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                got = '{o_score, o_rate_hit, o_fanout_hit, o_window_count,
                        o_distinct_count, o_tracked_count};
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) $display("result with no request waiting");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < 10)
                            $display("mismatch exp score %0d rh %0d fh %0d cnt %0d dist %0d trk %0d",
                                     want.score, want.rate_hit, want.fanout_hit,
                                     want.window_count, want.distinct_count, want.tracked_count,
                                     "  got score %0d rh %0d fh %0d cnt %0d dist %0d trk %0d",
                                     got.score, got.rate_hit, got.fanout_hit,
                                     got.window_count, got.distinct_count, got.tracked_count);
                        mismatches++;
                    end
                end
            end
            if (push && !full)
                expected_results.push_back(score_request(i_action, i_actor_pid,
                                                         i_remote_id, i_time_ms));
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// top of the egress rate and fanout monitor testbench: clock, reset, requests,
// register writes and the verdict; depends on ppm_pkg, egress_monitor_checker and the block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ppm_pkg::*;

    localparam logic [1:0] ACT_OTHER = 2'd1;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    localparam logic [1:0] CFG_NONE  = 2'd3;
    localparam int         STALL_LIMIT = 400000;

    logic               i_clk, i_rst_n, push, full, empty, pop;
    logic [1:0]         i_action;
    logic [PID_W-1:0]   i_actor_pid;
    logic [REM_W-1:0]   i_remote_id;
    logic [TIME_W-1:0]  i_time_ms;
    logic [6:0]         o_score, o_tracked_count;
    logic               o_rate_hit, o_fanout_hit, i_cfg_valid, o_cfg_ready;
    logic [8:0]         o_window_count, o_distinct_count;
    logic [1:0]         i_cfg_index;
    logic [CFG_W-1:0]   i_cfg_data;
    int                 mismatches, outstanding, quiet_cycles, pop_mode, pop_tick;

    per_process_egress_rate_fanout_monitor u_top (.*);

    egress_monitor_checker u_check (.*);

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // result side stalls on its own pattern
    always @(negedge i_clk) begin
        pop_tick <= pop_tick + 1;
        if (pop_tick % 97 == 0) pop_mode <= $urandom_range(0, 3);
        case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= $urandom_range(0, 1);
            2: pop <= ($urandom_range(0, 5) == 0);
            default: pop <= pop_tick[2];
        endcase
    end

    task automatic send_request(logic [1:0] act, logic [PID_W-1:0] pid,
                                logic [REM_W-1:0] rem, logic [TIME_W-1:0] t);
        @(negedge i_clk);
        push        = 1'b1;
        i_action    = act;
        i_actor_pid = pid;
        i_remote_id = rem;
        i_time_ms   = t;
        while (full) @(negedge i_clk);
    endtask

    task automatic hold_sender(int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            push = 1'b0;
        end
    endtask

    // sender waits until every result has come back
    task automatic wait_drained();
        hold_sender(1);
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // random traffic over a pool of pids, in bursts with gaps
    task automatic run_phase(int items, int npids, int div, logic [63:0] wms);
        logic [PID_W-1:0]  pids [80];
        logic [REM_W-1:0]  hosts [12];
        logic [TIME_W-1:0] t, at;
        logic [1:0]        act;
        logic [PID_W-1:0]  pid;
        logic [REM_W-1:0]  rem;
        int                counted, burst, sel, jump;
        foreach (pids[k]) pids[k] = $urandom_range(1, 22'h3FFFFF);
        foreach (hosts[k]) hosts[k] = $urandom;
        t = {1'b0, 15'($urandom), 32'($urandom)};
        counted = 0;
        burst = 0;
        while (counted < items) begin
            if (burst == 0) begin
                if ($urandom_range(0, 3) != 0) hold_sender($urandom_range(1, 15));
                burst = $urandom_range(1, 12);
            end
            burst--;
            sel = $urandom_range(0, 99);
            if (sel < 80)      act = ACT_CONNECT;
            else if (sel < 87) act = ACT_FORGET;
            else if (sel < 94) act = ACT_OTHER;
            else               act = ACT_SPARE;
            pid = pids[$urandom_range(0, npids - 1)];
            if ($urandom_range(0, 49) == 0) pid = '0;
            rem = $urandom_range(0, 1) ? hosts[$urandom_range(0, 11)] : $urandom;
            jump = $urandom_range(0, 99);
            if (jump == 0) t = t + TIME_W'(wms * 5);
            t = t + TIME_W'($urandom_range(0, 32'(wms / div)));
            at = t;
            if (jump < 4 && t > TIME_W'(wms * 2)) at = t - $urandom_range(0, 32'(wms * 2));
            send_request(act, pid, rem, at);
            counted++;
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        pop_mode = 0;
        pop_tick = 0;
        quiet_cycles = 0;
        i_action = ACT_CONNECT;
        i_actor_pid = '0;
        i_remote_id = '0;
        i_time_ms = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WINDOW;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: ignored items, field extremes, forget, rule hits, late times
        send_request(ACT_OTHER, 22'd5, 32'd1, '0);
        send_request(ACT_SPARE, 22'd5, 32'd1, '0);
        send_request(ACT_CONNECT, '0, 32'd1, '0);
        send_request(ACT_CONNECT, 22'h3FFFFF, '0, '0);
        send_request(ACT_CONNECT, 22'h3FFFFF, 32'hFFFF_FFFF, 48'd1000);
        send_request(ACT_FORGET, 22'h3FFFFF, '0, '0);
        send_request(ACT_FORGET, 22'd12345, '0, '0);
        for (int k = 0; k < 14; k++)
            send_request(ACT_CONNECT, 22'd9, 32'h100 + k, 48'd20000 + k * 100);
        send_request(ACT_CONNECT, 22'd9, 32'h100, 48'd21500);
        // an entry older than the one in front stays but is not counted
        send_request(ACT_CONNECT, 22'd7, 32'd1, 48'd200000);
        send_request(ACT_CONNECT, 22'd7, 32'd2, 48'd100000);
        send_request(ACT_CONNECT, 22'd7, 32'd3, 48'd200100);
        // far future time makes every other pid idle
        send_request(ACT_CONNECT, 22'd1, 32'h5A5A_A5A5, 48'hFFFF_FFFF_FFFF);
        run_phase(234, 6, 40, 64'd10000);

        // shortest window, many pids to force capacity eviction
        wait_drained();
        write_register(CFG_WINDOW, 16'd1);
        run_phase(234, 80, 300, 64'd1000);

        // zero window falls back to ten seconds, thresholds below range
        wait_drained();
        write_register(CFG_WINDOW, 16'd0);
        write_register(CFG_RATE, 16'd3);
        write_register(CFG_FANOUT, 16'd2);
        write_register(CFG_NONE, 16'hFFFF);
        run_phase(234, 4, 100, 64'd10000);

        // widest window and thresholds
        wait_drained();
        write_register(CFG_WINDOW, 16'hFFFF);
        write_register(CFG_RATE, 16'hFFFF);
        write_register(CFG_FANOUT, 16'hFFFF);
        run_phase(234, 8, 40, 64'd65535000);

        wait_drained();
        write_register(CFG_WINDOW, 16'd5);
        write_register(CFG_RATE, 16'd12);
        write_register(CFG_FANOUT, 16'd9);
        run_phase(234, 5, 40, 64'd5000);

        // drain and settle
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/ppm_pkg.sv
sv/ppm_front.sv
sv/ppm_back.sv
sv/per_process_egress_rate_fanout_monitor.sv
tb/sv/egress_monitor_checker.sv
tb/sv/tb_top.sv
